// File: rtl/frt_pkg.sv
// Shared definitions for the quarter-turn frame rotator.
// No dependencies; imported by every rtl module of the block.
`default_nettype none

package frt_pkg;

	// Default sizing of the frame store
	localparam int DEF_MAX_SIDE   = 64;
	localparam int DEF_PIXEL_BITS = 24;

	// Fixed port widths
	localparam int PIX_PORT_BITS = 24;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 7;
	localparam int SIDE_REG_BITS = 7;
	localparam int TURN_REG_BITS = 4;

	// Register map
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_QUARTER_TURNS = 2'd2;

	// Request commands
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// Net clockwise turn
	localparam logic [1:0] TURN_0   = 2'd0;
	localparam logic [1:0] TURN_90  = 2'd1;
	localparam logic [1:0] TURN_180 = 2'd2;
	localparam logic [1:0] TURN_270 = 2'd3;

	// Memory access issued by the address stage
	typedef struct packed {
		logic valid;
		logic write;
		logic not_ready;
		logic last;
	} frt_req_t;

endpackage

`default_nettype wire

// File: rtl/frt_cfg.sv
// Configuration registers and derived frame geometry.
// Depends on frt_pkg.
`default_nettype none

module frt_cfg import frt_pkg::*; #(
	parameter int MAX_SIDE = DEF_MAX_SIDE
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	input  wire logic [CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
	output logic                           clear,
	output logic [$clog2(MAX_SIDE+1)-1:0]  w,
	output logic [$clog2(MAX_SIDE+1)-1:0]  h,
	output logic [1:0]                     turn,
	output logic [$clog2(MAX_SIDE+1)-1:0]  ow,
	output logic [$clog2(MAX_SIDE+1)-1:0]  oh,
	output logic [$clog2(MAX_SIDE*MAX_SIDE+1)-1:0] total
);

	localparam int SVW      = $clog2(MAX_SIDE+1);
	localparam int CW       = $clog2(MAX_SIDE*MAX_SIDE+1);
	localparam int CMPW     = (SVW > SIDE_REG_BITS) ? SVW : SIDE_REG_BITS;
	localparam int RST_SIDE = (MAX_SIDE < 64) ? MAX_SIDE : 64;

	logic [SVW-1:0]           w_q, h_q, ow_q, oh_q, side_new;
	logic [TURN_REG_BITS-1:0] turn_q;
	logic [CW-1:0]            total_q;
	logic [CMPW-1:0]          data_ext;

	// zero reads as one, anything above the store side saturates
	always_comb begin
		data_ext = CMPW'(cfg_data[SIDE_REG_BITS-1:0]);
		if (data_ext == '0) begin
			side_new = SVW'(1);
		end else if (data_ext > CMPW'(MAX_SIDE)) begin
			side_new = SVW'(MAX_SIDE);
		end else begin
			side_new = SVW'(data_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= SVW'(RST_SIDE);
			h_q    <= SVW'(RST_SIDE);
			turn_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_WIDTH:   w_q    <= side_new;
				REG_FRAME_HEIGHT:  h_q    <= side_new;
				REG_QUARTER_TURNS: turn_q <= cfg_data[TURN_REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// geometry is registered from the configuration registers and follows them in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ow_q    <= SVW'(RST_SIDE);
			oh_q    <= SVW'(RST_SIDE);
			total_q <= CW'(RST_SIDE * RST_SIDE);
		end else begin
			ow_q    <= turn_q[0] ? h_q : w_q;
			oh_q    <= turn_q[0] ? w_q : h_q;
			total_q <= CW'(w_q * h_q);
		end
	end

	assign clear = cfg_valid && (cfg_index == REG_FRAME_WIDTH ||
		cfg_index == REG_FRAME_HEIGHT || cfg_index == REG_QUARTER_TURNS);
	assign w     = w_q;
	assign h     = h_q;
	assign turn  = turn_q[1:0];
	assign ow    = ow_q;
	assign oh    = oh_q;
	assign total = total_q;

endmodule

`default_nettype wire

// File: rtl/frt_addr.sv
// Request register, load/drain counters and rotated address generation.
// Depends on frt_pkg.
`default_nettype none

module frt_addr import frt_pkg::*; #(
	parameter int MAX_SIDE   = DEF_MAX_SIDE,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      accept,
	input  wire logic                      command,
	input  wire logic [PIX_PORT_BITS-1:0]  pixel_in,
	input  wire logic                      clear,
	input  wire logic [$clog2(MAX_SIDE+1)-1:0] w,
	input  wire logic [$clog2(MAX_SIDE+1)-1:0] h,
	input  wire logic [1:0]                turn,
	input  wire logic [$clog2(MAX_SIDE+1)-1:0] ow,
	input  wire logic [$clog2(MAX_SIDE+1)-1:0] oh,
	input  wire logic [$clog2(MAX_SIDE*MAX_SIDE+1)-1:0] total,
	output frt_req_t                       req,
	output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] addr,
	output logic [PIXEL_BITS-1:0]          wdata
);

	localparam int SVW = $clog2(MAX_SIDE+1);
	localparam int SW  = $clog2(MAX_SIDE);
	localparam int CW  = $clog2(MAX_SIDE*MAX_SIDE+1);
	localparam int AW  = $clog2(MAX_SIDE*MAX_SIDE);
	localparam int PW  = SW + SVW + 1;

	logic                     valid_s1, cmd_s1;
	logic [PIX_PORT_BITS-1:0] pix_s1;

	logic [CW-1:0] cnt_q;
	logic [SW-1:0] row_q, col_q;
	logic          full_q;

	logic          restart, wrap, last, is_load;
	logic [CW-1:0] base, cnt_inc;
	logic [SW-1:0] row_c, col_c, sr, sc, hm1, wm1, owm1;
	logic [PW-1:0] raddr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= command;
			pix_s1 <= pixel_in;
		end
	end

	always_comb begin
		is_load = (cmd_s1 == CMD_LOAD);
		// a load after a complete frame starts a new one
		restart = full_q || (cnt_q >= total);
		base    = restart ? '0 : cnt_q;
		cnt_inc = base + CW'(1);

		wrap  = (SVW'(row_q) >= oh) || (SVW'(col_q) >= ow);
		row_c = wrap ? '0 : row_q;
		col_c = wrap ? '0 : col_q;

		hm1  = SW'(h - SVW'(1));
		wm1  = SW'(w - SVW'(1));
		owm1 = SW'(ow - SVW'(1));

		case (turn)
			TURN_90: begin
				sr = hm1 - col_c;
				sc = row_c;
			end
			TURN_180: begin
				sr = hm1 - row_c;
				sc = wm1 - col_c;
			end
			TURN_270: begin
				sr = col_c;
				sc = wm1 - row_c;
			end
			default: begin
				sr = row_c;
				sc = col_c;
			end
		endcase

		raddr = PW'(sr) * PW'(w) + PW'(sc);
		last  = (SVW'(row_c) == oh - SVW'(1)) && (col_c == owm1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			row_q  <= '0;
			col_q  <= '0;
			full_q <= 1'b0;
		end else if (clear) begin
			cnt_q  <= '0;
			row_q  <= '0;
			col_q  <= '0;
			full_q <= 1'b0;
		end else if (valid_s1) begin
			if (is_load) begin
				cnt_q <= cnt_inc;
				if (cnt_inc >= total) begin
					full_q <= 1'b1;
					row_q  <= '0;
					col_q  <= '0;
				end else if (restart) begin
					full_q <= 1'b0;
					row_q  <= '0;
					col_q  <= '0;
				end
			end else if (full_q) begin
				if (last) begin
					row_q <= '0;
					col_q <= '0;
				end else if (col_c == owm1) begin
					row_q <= row_c + SW'(1);
					col_q <= '0;
				end else begin
					row_q <= row_c;
					col_q <= col_c + SW'(1);
				end
			end
		end
	end

	assign req.valid     = valid_s1;
	assign req.write     = valid_s1 && is_load;
	assign req.not_ready = !is_load && !full_q;
	assign req.last      = !is_load && full_q && last;
	assign addr          = is_load ? base[AW-1:0] : raddr[AW-1:0];
	assign wdata         = pix_s1[PIXEL_BITS-1:0];

endmodule

`default_nettype wire

// File: rtl/frt_store.sv
// Frame memory with registered read data and the result register.
// Depends on frt_pkg.
`default_nettype none

module frt_store import frt_pkg::*; #(
	parameter int MAX_SIDE   = DEF_MAX_SIDE,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire frt_req_t                  req,
	input  wire logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] addr,
	input  wire logic [PIXEL_BITS-1:0]     wdata,
	output logic                           done,
	output logic [PIX_PORT_BITS-1:0]       pixel_out,
	output logic                           last_pixel,
	output logic                           not_ready
);

	localparam int DEPTH = MAX_SIDE * MAX_SIDE;

	logic [PIXEL_BITS-1:0] mem [DEPTH];
	logic [PIXEL_BITS-1:0] rdata_s2;
	logic                  done_s2, last_s2, nr_s2;

	always_ff @(posedge clk) begin
		if (req.write) begin
			mem[addr] <= wdata;
		end
		if (req.valid && !req.write && !req.not_ready) begin
			rdata_s2 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
			last_s2 <= 1'b0;
			nr_s2   <= 1'b0;
		end else begin
			done_s2 <= req.valid && !req.write;
			last_s2 <= req.last;
			nr_s2   <= req.not_ready;
		end
	end

	assign done       = done_s2;
	assign pixel_out  = nr_s2 ? '0 : PIX_PORT_BITS'(rdata_s2);
	assign last_pixel = last_s2;
	assign not_ready  = nr_s2;

endmodule

`default_nettype wire

// File: rtl/frame_rotate_quarter_turns.sv
// Top level of the quarter-turn frame rotator.
// Depends on frt_pkg, frt_cfg, frt_addr and frt_store.
//
// One request is taken every cycle (busy never rises). A load request writes
// the next pixel of the frame in row-major order and gives no result. A drain
// request gives one result, strobed by done for a single cycle once it has
// passed valid_s1 and done_s2; it cannot be held off, so the receiver must
// take it then. The rate is one request per clock, set by the single port of
// the frame memory, which serves one write or one read a cycle. The store has
// no clearing pass: a drain only returns pixels of a fully loaded frame, and
// flags not_ready otherwise. Configuration writes are always accepted
// (cfg_ready stays high), abandon the current frame, and take effect for
// requests issued from the next cycle on.
`default_nettype none

module frame_rotate_quarter_turns import frt_pkg::*; #(
	parameter int MAX_SIDE   = DEF_MAX_SIDE,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic                      command,
	input  wire logic [PIX_PORT_BITS-1:0]  pixel_in,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
	output logic                           done,
	output logic [PIX_PORT_BITS-1:0]       pixel_out,
	output logic                           last_pixel,
	output logic                           not_ready
);

	localparam int SVW = $clog2(MAX_SIDE+1);
	localparam int CW  = $clog2(MAX_SIDE*MAX_SIDE+1);
	localparam int AW  = $clog2(MAX_SIDE*MAX_SIDE);

	logic                  clear;
	logic [SVW-1:0]        w, h, ow, oh;
	logic [1:0]            turn;
	logic [CW-1:0]         total;
	frt_req_t              req;
	logic [AW-1:0]         addr;
	logic [PIXEL_BITS-1:0] wdata;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	frt_cfg #(
		.MAX_SIDE (MAX_SIDE)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.clear     (clear),
		.w         (w),
		.h         (h),
		.turn      (turn),
		.ow        (ow),
		.oh        (oh),
		.total     (total)
	);

	frt_addr #(
		.MAX_SIDE   (MAX_SIDE),
		.PIXEL_BITS (PIXEL_BITS)
	) u_addr (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (start && !busy),
		.command  (command),
		.pixel_in (pixel_in),
		.clear    (clear),
		.w        (w),
		.h        (h),
		.turn     (turn),
		.ow       (ow),
		.oh       (oh),
		.total    (total),
		.req      (req),
		.addr     (addr),
		.wdata    (wdata)
	);

	frt_store #(
		.MAX_SIDE   (MAX_SIDE),
		.PIXEL_BITS (PIXEL_BITS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.addr       (addr),
		.wdata      (wdata),
		.done       (done),
		.pixel_out  (pixel_out),
		.last_pixel (last_pixel),
		.not_ready  (not_ready)
	);

endmodule

`default_nettype wire
